// ===== src/prs_lz_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_lz_pkg: shared types and constants of the PRS LZ decompressor
// Holds the command record passed from the stream parser to the copy engine,
// along with the field widths and stream constants.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_lz_pkg;

	// Defaults for the top-level parameters.
	localparam int HISTORY_DEPTH_DEF = 8192;
	localparam int OUT_LANES_DEF     = 8;

	// At most this many results are delivered for one input transaction.
	localparam int MAX_RESULTS = 32;
	localparam int RES_W       = $clog2(MAX_RESULTS) + 1;

	// A copy distance runs from 1 to 8192; a copy length from 1 to 256.
	localparam int DIST_W = 14;
	localparam int LEN_W  = 9;

	localparam int SHORT_SPAN = 256;
	localparam int LONG_SPAN  = 8192;

	localparam int                TOTAL_W   = 24;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_RESTART = 3'd1,
		CMD_LIT     = 3'd2,
		CMD_COPY    = 3'd3,
		CMD_END     = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		logic              valid;
		cmd_kind_t         kind;
		logic [7:0]        lit;
		logic [DIST_W-1:0] distance;
		logic [LEN_W-1:0]  len;
	} cmd_t;

endpackage

`default_nettype wire

// ===== src/prs_lz_if.sv =====
// ----------------------------------------------------------------------------
// prs_lz_if: valid/ready channels of the PRS LZ decompressor
// The input channel carries one compressed byte per transaction; the output
// channel carries up to eight decoded bytes per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_lz_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_of_stream;

	modport source (output valid, output in_byte, output start_of_stream, input ready);
	modport sink   (input valid, input in_byte, input start_of_stream, output ready);
endinterface

interface prs_lz_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_data;
	logic [3:0]  out_count;
	logic        run_last;
	logic        end_of_stream;
	logic [23:0] total_length;

	modport source (
		output valid, output out_data, output out_count, output run_last,
		output end_of_stream, output total_length, input ready
	);
	modport sink (
		input valid, input out_data, input out_count, input run_last,
		input end_of_stream, input total_length, output ready
	);
endinterface

`default_nettype wire

// ===== src/prs_lz_parser.sv =====
// ----------------------------------------------------------------------------
// prs_lz_parser: control-bit and token parser
// Consumes one compressed byte per transaction, tracks the control byte and
// the token phase, and hands a literal, copy or end command to the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_lz_parser import prs_lz_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	prs_lz_in_if.sink      in_ch,
	input  logic           engine_idle,
	output cmd_t           cmd
);

	typedef enum logic [7:0] {
		PH_FLAG     = 8'b0000_0001,
		PH_KIND     = 8'b0000_0010,
		PH_SHORTLEN = 8'b0000_0100,
		PH_LITERAL  = 8'b0000_1000,
		PH_SHORTOFF = 8'b0001_0000,
		PH_LONGLO   = 8'b0010_0000,
		PH_LONGHI   = 8'b0100_0000,
		PH_LONGCNT  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [7:0]       ctrl;
		logic [3:0]       left;
		logic [LEN_W-1:0] plen;
	} bits_t;

	// Walks the remaining control bits while the parser still needs flag bits.
	function automatic bits_t run_bits(bits_t s);
		bits_t r;
		logic  b;
		r = s;
		for (int i = 0; i < 8; i++) begin
			if (r.left != 4'd0 &&
			    (r.phase == PH_FLAG || r.phase == PH_KIND || r.phase == PH_SHORTLEN)) begin
				b      = r.ctrl[0];
				r.ctrl = r.ctrl >> 1;
				r.left = r.left - 4'd1;
				case (r.phase)
					PH_FLAG: begin
						r.phase = b ? PH_LITERAL : PH_KIND;
					end
					PH_KIND: begin
						if (b) begin
							r.phase = PH_LONGLO;
						end else begin
							r.plen  = LEN_W'(1);
							r.phase = PH_SHORTLEN;
						end
					end
					default: begin
						r.plen = {r.plen[LEN_W-2:0], b};
						if (r.plen >= LEN_W'(4)) begin
							r.phase = PH_SHORTOFF;
						end
					end
				endcase
			end
		end
		return r;
	endfunction

	phase_t           phase_q, phase_n;
	logic [7:0]       ctrl_q, ctrl_n;
	logic [3:0]       left_q, left_n;
	logic [7:0]       plow_q, plow_n;
	logic [LEN_W-1:0] plen_q, plen_n;
	logic             done_q, done_n;

	logic             accept;
	logic [15:0]      word;
	logic [15:0]      word_cnt;
	bits_t            walked;

	assign in_ch.ready = engine_idle;
	assign accept      = in_ch.valid && in_ch.ready;
	assign word        = {in_ch.in_byte, plow_q};
	assign word_cnt    = {plen_q[7:0], plow_q};

	always_comb begin
		phase_n   = phase_q;
		ctrl_n    = ctrl_q;
		left_n    = left_q;
		plow_n    = plow_q;
		plen_n    = plen_q;
		done_n    = done_q;
		cmd       = '0;
		cmd.valid = accept;
		cmd.kind  = CMD_NONE;

		if (in_ch.start_of_stream) begin
			phase_n  = PH_FLAG;
			ctrl_n   = in_ch.in_byte;
			left_n   = 4'd8;
			plow_n   = '0;
			plen_n   = '0;
			done_n   = 1'b0;
			cmd.kind = CMD_RESTART;
		end else if (done_q) begin
			cmd.kind = CMD_NONE;
		end else begin
			case (phase_q)
				PH_LITERAL: begin
					cmd.kind = CMD_LIT;
					cmd.lit  = in_ch.in_byte;
					phase_n  = PH_FLAG;
				end
				PH_SHORTOFF: begin
					cmd.kind     = CMD_COPY;
					cmd.distance = DIST_W'(SHORT_SPAN) - DIST_W'(in_ch.in_byte);
					cmd.len      = LEN_W'(plen_q[1:0]) + LEN_W'(2);
					phase_n      = PH_FLAG;
				end
				PH_LONGLO: begin
					plow_n  = in_ch.in_byte;
					phase_n = PH_LONGHI;
				end
				PH_LONGHI: begin
					if (word == 16'd0) begin
						done_n   = 1'b1;
						phase_n  = PH_FLAG;
						left_n   = 4'd0;
						ctrl_n   = 8'd0;
						cmd.kind = CMD_END;
					end else if (word[2:0] != 3'd0) begin
						cmd.kind     = CMD_COPY;
						cmd.distance = DIST_W'(LONG_SPAN) - DIST_W'(word[15:3]);
						cmd.len      = LEN_W'(word[2:0]) + LEN_W'(2);
						phase_n      = PH_FLAG;
					end else begin
						plen_n  = LEN_W'(in_ch.in_byte);
						phase_n = PH_LONGCNT;
					end
				end
				PH_LONGCNT: begin
					cmd.kind     = CMD_COPY;
					cmd.distance = DIST_W'(LONG_SPAN) - DIST_W'(word_cnt[15:3]);
					cmd.len      = LEN_W'(in_ch.in_byte) + LEN_W'(1);
					phase_n      = PH_FLAG;
				end
				default: begin
					// Flag-bit phases: this byte is a fresh control byte.
					ctrl_n = in_ch.in_byte;
					left_n = 4'd8;
				end
			endcase
		end

		walked = run_bits({phase_n, ctrl_n, left_n, plen_n});
		if (!done_n) begin
			phase_n = walked.phase;
			ctrl_n  = walked.ctrl;
			left_n  = walked.left;
			plen_n  = walked.plen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			ctrl_q  <= '0;
			left_q  <= '0;
			plow_q  <= '0;
			plen_q  <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			ctrl_q  <= ctrl_n;
			left_q  <= left_n;
			plow_q  <= plow_n;
			plen_q  <= plen_n;
			done_q  <= done_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/prs_lz_copy.sv =====
// ----------------------------------------------------------------------------
// prs_lz_copy: history memory, copy engine and output packer
// Reads the history ring one byte per cycle when not stalled, writes each
// decoded byte back, packs bytes into results and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_lz_copy import prs_lz_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int OUT_LANES     = OUT_LANES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output logic        idle,
	prs_lz_out_if.source out_ch
);

	localparam int               AW        = $clog2(HISTORY_DEPTH);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(HISTORY_DEPTH - 1);
	localparam logic [AW:0]      DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);
	localparam logic [3:0]       LANES     = 4'(OUT_LANES);
	localparam logic [RES_W-1:0] RES_MAX   = RES_W'(MAX_RESULTS);

	logic [7:0] hist_mem [HISTORY_DEPTH];

	logic [AW-1:0]      wp_q, rd_ptr_q;
	logic [LEN_W-1:0]   rem_q;
	logic               lit_mode_q;
	logic [7:0]         lit_q;
	logic [RES_W-1:0]   res_idx_q;
	logic [TOTAL_W-1:0] total_q;
	logic [63:0]        acc_data_q;
	logic [3:0]         acc_cnt_q;
	logic               end_pend_q;

	logic               valid_s1, last_s1, lit_s1, fwd_s1;
	logic [7:0]         fwd_data_s1, hist_rd_s1;

	logic               out_valid_q, out_last_q, out_end_q;
	logic [63:0]        out_data_q;
	logic [3:0]         out_count_q;
	logic [TOTAL_W-1:0] out_total_q;

	logic               out_free, flush, emit, stall, advance, issue, end_push, out_load;
	logic [7:0]         byte_s1;
	logic [63:0]        acc_ins;
	logic [3:0]         cnt_inc;
	logic [TOTAL_W-1:0] total_inc;
	logic [AW:0]        src_diff;
	logic [AW-1:0]      src_start;

	function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
		return (p == LAST_ADDR) ? '0 : p + AW'(1);
	endfunction

	always_comb begin
		byte_s1 = lit_s1 ? lit_q : (fwd_s1 ? fwd_data_s1 : hist_rd_s1);
		for (int k = 0; k < 8; k++) begin
			acc_ins[8*k +: 8] = (acc_cnt_q[2:0] == 3'(k)) ? byte_s1 : acc_data_q[8*k +: 8];
		end
	end

	assign out_free  = !out_valid_q || out_ch.ready;
	assign cnt_inc   = acc_cnt_q + 4'd1;
	assign flush     = valid_s1 && (cnt_inc == LANES || last_s1);
	assign emit      = flush && (res_idx_q < RES_MAX);
	assign stall     = emit && !out_free;
	assign advance   = valid_s1 && !stall;
	assign issue     = (rem_q != '0) && !stall;
	assign end_push  = end_pend_q && out_free;
	assign out_load  = emit && advance;
	assign total_inc = (total_q == TOTAL_MAX) ? total_q : total_q + TOTAL_W'(1);
	assign idle      = (rem_q == '0) && !valid_s1 && !end_pend_q;

	// Source of the first copied byte, wrapped back into the ring.
	assign src_diff  = {1'b0, wp_q} - (AW+1)'(cmd.distance);
	assign src_start = src_diff[AW] ? AW'(src_diff + DEPTH_EXT) : src_diff[AW-1:0];

	// History ring: at most one write and one registered read per cycle; both wait while the output stalls.
	always_ff @(posedge clk) begin
		if (advance) begin
			hist_mem[wp_q] <= byte_s1;
		end
		if (issue && !lit_mode_q) begin
			hist_rd_s1 <= hist_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rd_ptr_q    <= '0;
			rem_q       <= '0;
			lit_mode_q  <= 1'b0;
			res_idx_q   <= '0;
			total_q     <= '0;
			acc_data_q  <= '0;
			acc_cnt_q   <= '0;
			end_pend_q  <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				rem_q    <= rem_q - LEN_W'(1);
				rd_ptr_q <= ptr_inc(rd_ptr_q);
				valid_s1 <= 1'b1;
			end else if (!stall) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				wp_q    <= ptr_inc(wp_q);
				total_q <= total_inc;
				if (flush) begin
					acc_cnt_q  <= '0;
					acc_data_q <= '0;
					if (emit) begin
						res_idx_q <= res_idx_q + RES_W'(1);
					end
				end else begin
					acc_cnt_q  <= cnt_inc;
					acc_data_q <= acc_ins;
				end
			end

			if (out_load || end_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (end_push) begin
				end_pend_q <= 1'b0;
			end

			// Commands arrive only while the engine is idle.
			if (cmd.valid) begin
				case (cmd.kind)
					CMD_RESTART: begin
						wp_q    <= '0;
						total_q <= '0;
					end
					CMD_LIT: begin
						rem_q      <= LEN_W'(1);
						lit_mode_q <= 1'b1;
						res_idx_q  <= '0;
					end
					CMD_COPY: begin
						rem_q      <= cmd.len;
						lit_mode_q <= 1'b0;
						rd_ptr_q   <= src_start;
						res_idx_q  <= '0;
					end
					CMD_END: begin
						end_pend_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.kind == CMD_LIT) begin
			lit_q <= cmd.lit;
		end
		if (issue) begin
			last_s1     <= (rem_q == LEN_W'(1));
			lit_s1      <= lit_mode_q;
			// The byte written this cycle is the one the new read wants.
			fwd_s1      <= advance && (rd_ptr_q == wp_q);
			fwd_data_s1 <= byte_s1;
		end
		if (out_load) begin
			out_data_q  <= acc_ins;
			out_count_q <= cnt_inc;
			out_last_q  <= last_s1 || (res_idx_q == RES_MAX - RES_W'(1));
			out_end_q   <= 1'b0;
			out_total_q <= total_inc;
		end else if (end_push) begin
			out_data_q  <= '0;
			out_count_q <= '0;
			out_last_q  <= 1'b1;
			out_end_q   <= 1'b1;
			out_total_q <= total_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_data      = out_data_q;
	assign out_ch.out_count     = out_count_q;
	assign out_ch.run_last      = out_last_q;
	assign out_ch.end_of_stream = out_end_q;
	assign out_ch.total_length  = out_total_q;

endmodule

`default_nettype wire

// ===== src/prs_lz_decompressor.sv =====
// A literal byte passes through lit_q, the s1 stage and the output register.
// A copy makes one history-memory read and write per byte.
// Throughput: one input transaction at a time; the next is accepted once the copy engine drains.
// The output register holds a finished result, so input may be taken while it waits.
// Reset: arst_n clears the parser, pointers, counters and the output valid at once;
// the history memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// prs_lz_decompressor: streaming PRS LZ77 decompressor
// Takes one compressed byte per input transaction and delivers decoded bytes
// packed into results of up to OUT_LANES bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_lz_decompressor import prs_lz_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int OUT_LANES     = OUT_LANES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	prs_lz_in_if.sink    in_ch,
	prs_lz_out_if.source out_ch
);

	// The parser decodes control bits and token bytes. It raises a command on
	// every accepted transaction; the engine takes it in the same edge.
	cmd_t cmd;
	// High when no decoded byte is in flight and no end result is pending. The
	// parser only accepts a new transaction then, so commands never overlap.
	logic engine_idle;

	prs_lz_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.engine_idle (engine_idle),
		.cmd         (cmd)
	);

	// The copy engine owns the history ring and the write pointer. Each copied
	// byte is read into the s1 register and written back from it; a read of
	// the entry written in the same cycle is forwarded around the memory.
	prs_lz_copy #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.OUT_LANES     (OUT_LANES)
	) u_copy (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.idle   (engine_idle),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

// ===== src/prs_lz_checker.sv =====
// ----------------------------------------------------------------------------
// prs_lz_checker: port-level assertions for the PRS LZ decompressor
// Watches the top-level channels and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_lz_checker import prs_lz_pkg::*; #(
	parameter int OUT_LANES = OUT_LANES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_data,
	input logic [3:0]  out_count,
	input logic        run_last,
	input logic        end_of_stream
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_count))
		else $error("output transaction changed while stalled");

	// The end result is empty and closes its run.
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_stream |-> out_count == 4'd0 && out_data == 64'd0 && run_last)
		else $error("malformed end-of-stream result");

	// Every other result carries between one and OUT_LANES bytes.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_stream |-> out_count != 4'd0 && out_count <= 4'(OUT_LANES))
		else $error("result byte count out of range");

	// A new input transaction is taken only once the previous run has been closed.
	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || run_last)
		else $error("input accepted while a run is still open");

endmodule

bind prs_lz_decompressor prs_lz_checker #(.OUT_LANES(OUT_LANES)) u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_data      (out_ch.out_data),
	.out_count     (out_ch.out_count),
	.run_last      (out_ch.run_last),
	.end_of_stream (out_ch.end_of_stream)
);

`default_nettype wire
